// ===== sv/bvps_pkg.sv =====
// shared types, constants and color conversion for the bitmap video unit
// no dependencies
`default_nettype none

package bvps_pkg;

    localparam int VRAM_DEPTH      = 32768;
    localparam int VRAM_ADDR_W     = $clog2(VRAM_DEPTH);
    localparam int PAL_DEPTH       = 16;
    localparam int PAL_IDX_W       = $clog2(PAL_DEPTH);
    localparam int VISIBLE_COLUMNS = 224;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 9;

    localparam logic [15:0] SCROLL_ADDR = 16'h8100;
    localparam logic [15:0] SCROLL_MASK = 16'hFFF0;
    localparam logic [7:0]  PAL_PAGE    = 8'h80;

    localparam logic [7:0] TOP_OFFSET_RESET   = 8'd16;
    localparam logic [8:0] SCROLL_SPLIT_RESET = 9'd192;

    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_OFFSET   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_SPLIT = 1'b1;

    localparam logic OP_BUS_WRITE = 1'b0;
    localparam logic OP_PIXEL     = 1'b1;

    typedef struct packed {
        logic                   en;
        logic                   we;
        logic [VRAM_ADDR_W-1:0] addr;
        logic [7:0]             wdata;
    } t_vram_req;

    function automatic logic [7:0] level3(input logic [2:0] v);
        logic [7:0] l;
        case (v)
            3'd0: l = 8'h00;
            3'd1: l = 8'h24;
            3'd2: l = 8'h49;
            3'd3: l = 8'h6D;
            3'd4: l = 8'h92;
            3'd5: l = 8'hB6;
            3'd6: l = 8'hDB;
            default: l = 8'hFF;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] level2(input logic [1:0] v);
        logic [7:0] l;
        case (v)
            2'd0: l = 8'h00;
            2'd1: l = 8'h55;
            2'd2: l = 8'hAA;
            default: l = 8'hFF;
        endcase
        return l;
    endfunction

    // rgb 3-3-2 to rgb565 with its bytes swapped
    function automatic logic [15:0] rgb332_to_565s(input logic [7:0] v);
        logic [7:0]  r8;
        logic [7:0]  g8;
        logic [7:0]  b8;
        logic [15:0] c;
        r8 = level3(v[2:0]);
        g8 = level3(v[5:3]);
        b8 = level2(v[7:6]);
        c  = {r8[7:3], g8[7:2], b8[7:3]};
        return {c[7:0], c[15:8]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/bitmap_video_with_palette_and_scroll.sv =====
// top level of the bitmap video unit: bus write decode, palette, scroll, pixel lookup
// uses bvps_pkg and bvps_vram
`default_nettype none

// Takes one request per clock while o_in_stall is low: a CPU bus write (video memory,
// palette or scroll) or a pixel request. A pixel request passes through the input register,
// the video memory read register and the palette lookup into the output register. The
// whole pipeline moves together and holds while the output is stalled. After reset the
// video memory is cleared one byte per cycle, and o_in_stall stays high while it clears;
// configuration writes are taken at any time (o_cfg_ready is always high).
module bitmap_video_with_palette_and_scroll (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_opcode,
    input  wire logic [15:0]                      i_bus_address,
    input  wire logic [7:0]                       i_bus_data,
    input  wire logic [7:0]                       i_display_line,
    input  wire logic [7:0]                       i_display_column,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [15:0]                           o_pixel_colour,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [bvps_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [bvps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bvps_pkg::*;

    logic [7:0]  r_top_offset;
    logic [8:0]  r_scroll_split;
    logic [7:0]  r_scroll;
    logic [15:0] r_pal [PAL_DEPTH];

    logic        r_a_valid;
    logic        r_a_op;
    logic [15:0] r_a_addr;
    logic [7:0]  r_a_data;
    logic [7:0]  r_a_line;
    logic [7:0]  r_a_col;

    logic        r_b_valid;
    logic        r_b_hi;
    logic        r_b_blank;

    logic        r_out_valid;
    logic [15:0] r_out_colour;

    logic        adv;
    logic        vram_busy;
    logic [7:0]  vram_rdata;
    t_vram_req   vram_req;

    logic [7:0]  game_x;
    logic [7:0]  offset;
    logic [7:0]  bline;
    logic        blank;
    logic        is_vram;
    logic        is_pal;
    logic        is_scroll;
    logic [3:0]  nib;

    assign adv         = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !adv || vram_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_offset   <= TOP_OFFSET_RESET;
            r_scroll_split <= SCROLL_SPLIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TOP_OFFSET:   r_top_offset   <= i_cfg_data[7:0];
                CFG_SCROLL_SPLIT: r_scroll_split <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_in_valid && !vram_busy;
        end
        if (adv) begin
            r_a_op   <= i_opcode;
            r_a_addr <= i_bus_address;
            r_a_data <= i_bus_data;
            r_a_line <= i_display_line;
            r_a_col  <= i_display_column;
        end
    end

    // decode and address forming
    always_comb begin
        game_x    = ~r_a_line;
        is_vram   = !r_a_addr[15];
        is_pal    = r_a_addr[15:8] == PAL_PAGE;
        is_scroll = (r_a_addr & SCROLL_MASK) == SCROLL_ADDR;
        blank     = {1'b0, r_a_col} >= 9'(VISIBLE_COLUMNS);
        offset    = r_top_offset;
        if ({1'b0, game_x} < r_scroll_split) begin
            offset = r_top_offset + r_scroll;
        end
        bline = r_a_col + offset;

        vram_req = '0;
        case (r_a_op)
            OP_BUS_WRITE: begin
                vram_req.en    = adv && r_a_valid && is_vram;
                vram_req.we    = 1'b1;
                vram_req.addr  = r_a_addr[VRAM_ADDR_W-1:0];
                vram_req.wdata = r_a_data;
            end
            OP_PIXEL: begin
                vram_req.en   = adv && r_a_valid;
                vram_req.we   = 1'b0;
                vram_req.addr = {bline, game_x[7:1]};
            end
            default: ;
        endcase
    end

    bvps_vram u_vram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (vram_req),
        .o_rdata (vram_rdata),
        .o_busy  (vram_busy)
    );

    // palette and scroll writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll <= '0;
            for (int i = 0; i < PAL_DEPTH; i++) begin
                r_pal[i] <= '0;
            end
        end else if (adv && r_a_valid && r_a_op == OP_BUS_WRITE) begin
            if (is_pal) begin
                r_pal[r_a_addr[PAL_IDX_W-1:0]] <= rgb332_to_565s(r_a_data);
            end else if (is_scroll) begin
                r_scroll <= r_a_data;
            end
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid && r_a_op == OP_PIXEL;
        end
        if (adv) begin
            r_b_hi    <= game_x[0];
            r_b_blank <= blank;
        end
    end

    assign nib = r_b_hi ? vram_rdata[7:4] : vram_rdata[3:0];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_b_valid;
        end
        if (adv) begin
            r_out_colour <= r_b_blank ? 16'h0000 : r_pal[nib];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_colour = r_out_colour;

endmodule

`default_nettype wire

// ===== sv/bvps_vram.sv =====
// video memory, one byte-wide port with registered read data
// clears itself after reset, one byte per cycle; uses bvps_pkg
`default_nettype none

module bvps_vram (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire bvps_pkg::t_vram_req   i_req,
    output logic [7:0]                 o_rdata,
    output logic                       o_busy
);
    import bvps_pkg::*;

    logic [7:0]             r_mem [VRAM_DEPTH];
    logic [7:0]             r_rdata;
    logic [VRAM_ADDR_W-1:0] r_clr_addr;
    logic                   r_clearing;

    logic                   n_we;
    logic [VRAM_ADDR_W-1:0] n_waddr;
    logic [7:0]             n_wdata;

    always_comb begin
        if (r_clearing) begin
            n_we    = 1'b1;
            n_waddr = r_clr_addr;
            n_wdata = 8'h00;
        end else begin
            n_we    = i_req.en && i_req.we;
            n_waddr = i_req.addr;
            n_wdata = i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_clearing && i_req.en && !i_req.we) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == VRAM_ADDR_W'(VRAM_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clearing;

endmodule

`default_nettype wire

// ===== test/bitmap_video_with_palette_and_scroll_tb.sv =====
// self-checking bench for the bitmap video unit: directed table, then random phases
// keeps its own copy of video memory, palette, scroll and registers to predict pixels
// depends on bvps_pkg and bitmap_video_with_palette_and_scroll
`default_nettype none

module bitmap_video_with_palette_and_scroll_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bvps_pkg::*;

    localparam logic [63:0] LEVEL3_TBL = 64'hFF_DB_B6_92_6D_49_24_00;
    localparam logic [31:0] LEVEL2_TBL = 32'hFF_AA_55_00;
    localparam int          IDLE_PCT   = 28;
    localparam int          HOLD_CYCLES = 200;

    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  line;
        logic [7:0]  col;
        logic        typed;
        logic [15:0] colour;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_opcode;
    logic [15:0]            i_bus_address;
    logic [7:0]             i_bus_data;
    logic [7:0]             i_display_line;
    logic [7:0]             i_display_column;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [15:0]            o_pixel_colour;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    logic [7:0]  vram_img [0:VRAM_DEPTH-1];
    logic [15:0] pal_img [0:PAL_DEPTH-1];
    logic [7:0]  scroll_img;
    logic [7:0]  top_img;
    logic [8:0]  split_img;

    logic [15:0]      colour_q [$];
    logic [14:0]      written_q [$];
    t_stim_row        dir_q [$];
    int               mismatches;
    int               idle_pct;
    bit               quiet;
    bit               drain;
    bit               hold_off_req;

    bitmap_video_with_palette_and_scroll u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_bus_address    (i_bus_address),
        .i_bus_data       (i_bus_data),
        .i_display_line   (i_display_line),
        .i_display_column (i_display_column),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_pixel_colour   (o_pixel_colour),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [15:0] swapped565(input logic [7:0] v);
        int          ri;
        int          gi;
        int          bi;
        logic [7:0]  r8;
        logic [7:0]  g8;
        logic [7:0]  b8;
        logic [15:0] c;
        ri = v[2:0];
        gi = v[5:3];
        bi = v[7:6];
        r8 = LEVEL3_TBL[ri*8 +: 8];
        g8 = LEVEL3_TBL[gi*8 +: 8];
        b8 = LEVEL2_TBL[bi*8 +: 8];
        c  = {r8[7:3], g8[7:2], b8[7:3]};
        return {c[7:0], c[15:8]};
    endfunction

    function automatic logic [15:0] lookup_colour(input logic [7:0] line, input logic [7:0] col);
        logic [7:0] x;
        logic [7:0] off;
        logic [7:0] bline;
        logic [7:0] byte_rd;
        logic [3:0] nib;
        x   = 8'd255 - line;
        off = top_img;
        if (col >= VISIBLE_COLUMNS)
            return 16'h0000;
        if ({1'b0, x} < split_img)
            off = off + scroll_img;
        bline   = col + off;
        byte_rd = vram_img[{bline, x[7:1]}];
        nib     = x[0] ? byte_rd[7:4] : byte_rd[3:0];
        return pal_img[nib];
    endfunction

    // apply an accepted request to the mirror state, queue the color a pixel request yields
    task automatic commit_request(input t_stim_row r);
        if (r.op == OP_BUS_WRITE) begin
            if (r.addr < VRAM_DEPTH) begin
                vram_img[r.addr[14:0]] = r.data;
                written_q.push_back(r.addr[14:0]);
                if (written_q.size() > 48)
                    void'(written_q.pop_front());
            end else if (r.addr[15:8] == PAL_PAGE) begin
                pal_img[r.addr[3:0]] = swapped565(r.data);
            end else if ((r.addr & SCROLL_MASK) == SCROLL_ADDR) begin
                scroll_img = r.data;
            end
        end else if (r.typed) begin
            colour_q.push_back(r.colour);
        end else begin
            colour_q.push_back(lookup_colour(r.line, r.col));
        end
    endtask

    task automatic send_req(input t_stim_row r);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_opcode         <= r.op;
        i_bus_address    <= r.addr;
        i_bus_data       <= r.data;
        i_display_line   <= r.line;
        i_display_column <= r.col;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        commit_request(r);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_TOP_OFFSET)
            top_img = val[7:0];
        else
            split_img = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (colour_q.size() != 0)
            @(posedge i_clk);
        drain = 1'b1;
        repeat (8) @(posedge i_clk);
        drain = 1'b0;
    endtask

    function automatic t_stim_row mk_row(input logic op, input logic [15:0] addr,
                                         input logic [7:0] data, input logic [7:0] line,
                                         input logic [7:0] col, input logic typed,
                                         input logic [15:0] colour);
        t_stim_row r;
        r.op     = op;
        r.addr   = addr;
        r.data   = data;
        r.line   = line;
        r.col    = col;
        r.typed  = typed;
        r.colour = colour;
        return r;
    endfunction

    function automatic t_stim_row make_random_row();
        t_stim_row   r;
        int          pick;
        int          k;
        logic [14:0] a;
        logic        b;
        logic [7:0]  x;
        logic [7:0]  off;
        r       = '0;
        r.addr  = 16'($urandom);
        r.data  = 8'($urandom);
        r.line  = 8'($urandom);
        r.col   = 8'($urandom);
        r.op    = OP_BUS_WRITE;
        pick    = $urandom_range(99);
        if (pick < 35) begin
            r.addr[15] = 1'b0;
        end else if (pick < 45) begin
            r.addr[15:8] = PAL_PAGE;
        end else if (pick < 50) begin
            r.addr[15:4] = SCROLL_ADDR[15:4];
        end else if (pick < 55) begin
            r.addr = 16'($urandom_range(65535, 33040));
        end else begin
            r.op = OP_PIXEL;
            // aim most pixel requests at bytes written recently
            if ($urandom_range(99) < 75 && written_q.size() != 0) begin
                k   = $urandom_range(written_q.size() - 1);
                a   = written_q[k];
                b   = 1'($urandom);
                x   = {a[6:0], b};
                off = top_img;
                if ({1'b0, x} < split_img)
                    off = off + scroll_img;
                r.col  = a[14:7] - off;
                r.line = 8'd255 - x;
            end
        end
        return r;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_req(make_random_row());
    endtask

    // receiver side: random stall, one long hold-off on request, clear while draining or quiet
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                for (n = 1; n < HOLD_CYCLES; n++)
                    @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if (drain || quiet) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (colour_q.size() == 0) begin
                $error("pixel_colour unexpected result, actual %h", o_pixel_colour);
                mismatches++;
            end else begin
                if (o_pixel_colour !== colour_q[0]) begin
                    $error("pixel_colour expected %h actual %h", colour_q[0], o_pixel_colour);
                    mismatches++;
                end
                void'(colour_q.pop_front());
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_opcode         = OP_BUS_WRITE;
        i_bus_address    = '0;
        i_bus_data       = '0;
        i_display_line   = '0;
        i_display_column = '0;
        i_out_stall      = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = CFG_TOP_OFFSET;
        i_cfg_data       = '0;
        mismatches       = 0;
        idle_pct         = IDLE_PCT;
        quiet            = 1'b0;
        drain            = 1'b0;
        hold_off_req     = 1'b0;
        for (int j = 0; j < VRAM_DEPTH; j++)
            vram_img[j] = 8'h00;
        for (int j = 0; j < PAL_DEPTH; j++)
            pal_img[j] = 16'h0000;
        scroll_img = 8'h00;
        top_img    = TOP_OFFSET_RESET;
        split_img  = SCROLL_SPLIT_RESET;

        // after reset all reads give zero; then palette extremes, memory and scroll writes
        dir_q.push_back(mk_row(OP_PIXEL, 16'h0000, 8'h00, 8'd0, 8'd0, 1'b1, 16'h0000));
        dir_q.push_back(mk_row(OP_PIXEL, 16'h0000, 8'h00, 8'd255, 8'd223, 1'b1, 16'h0000));
        dir_q.push_back(mk_row(OP_PIXEL, 16'h0000, 8'h00, 8'd10, 8'd224, 1'b1, 16'h0000));
        dir_q.push_back(mk_row(OP_PIXEL, 16'h0000, 8'h00, 8'd10, 8'd255, 1'b1, 16'h0000));
        dir_q.push_back(mk_row(OP_BUS_WRITE, 16'h8000, 8'hFF, 8'd0, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_PIXEL, 16'h0000, 8'h00, 8'd0, 8'd0, 1'b1, 16'hFFFF));
        dir_q.push_back(mk_row(OP_PIXEL, 16'h0000, 8'h00, 8'd0, 8'd224, 1'b1, 16'h0000));
        dir_q.push_back(mk_row(OP_BUS_WRITE, 16'h80FF, 8'h00, 8'd0, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_BUS_WRITE, 16'h8001, 8'h07, 8'd0, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_BUS_WRITE, 16'h800E, 8'hC0, 8'd0, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_BUS_WRITE, 16'h8002, 8'h38, 8'd0, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_BUS_WRITE, 16'h0800, 8'h1E, 8'd0, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_PIXEL, 16'h0000, 8'h00, 8'd255, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_PIXEL, 16'h0000, 8'h00, 8'd254, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_BUS_WRITE, 16'h7FFF, 8'hF2, 8'd0, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_BUS_WRITE, 16'h8100, 8'h10, 8'd0, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_PIXEL, 16'h0000, 8'h00, 8'd255, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_BUS_WRITE, 16'h1000, 8'hE1, 8'd0, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_PIXEL, 16'h0000, 8'h00, 8'd64, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_PIXEL, 16'h0000, 8'h00, 8'd63, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_BUS_WRITE, 16'h810F, 8'hFF, 8'd0, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_BUS_WRITE, 16'h8110, 8'hAA, 8'd0, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_BUS_WRITE, 16'hFFFF, 8'h55, 8'd0, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_PIXEL, 16'h0000, 8'h00, 8'd0, 8'd0, 1'b0, 16'h0));
        dir_q.push_back(mk_row(OP_PIXEL, 16'h0000, 8'h00, 8'd255, 8'd17, 1'b0, 16'h0));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_q[i])
            send_req(dir_q[i]);
        run_random(80);

        // no idling on either side
        wait_idle();
        write_cfg(CFG_TOP_OFFSET, 9'd0);
        write_cfg(CFG_SCROLL_SPLIT, 9'd0);
        idle_pct = 0;
        quiet    = 1'b1;
        run_random(80);
        idle_pct = IDLE_PCT;
        quiet    = 1'b0;

        // top offset bit 8 is dropped; receiver holds off long enough to back up the input
        wait_idle();
        write_cfg(CFG_TOP_OFFSET, 9'h1FF);
        write_cfg(CFG_SCROLL_SPLIT, 9'd256);
        hold_off_req = 1'b1;
        run_random(80);

        wait_idle();
        write_cfg(CFG_TOP_OFFSET, 9'h080);
        write_cfg(CFG_SCROLL_SPLIT, 9'd511);
        run_random(80);

        wait_idle();
        write_cfg(CFG_TOP_OFFSET, 9'($urandom_range(511)));
        write_cfg(CFG_SCROLL_SPLIT, 9'($urandom_range(511)));
        run_random(80);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && colour_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
